// ===== rtl/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int IDX_W         = 6;
  localparam int NOTE_W        = 7;
  localparam int CH_W          = 4;
  localparam int EM_W          = 2;
  localparam int LVL_W         = 16;
  localparam int EMITTER_SLOTS = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 28;

  // Q1.15 full scale
  localparam logic [LVL_W:0] LEVEL_ONE = 17'h08000;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STG_ATTACK  = 2'd0,
    STG_DECAY   = 2'd1,
    STG_SUSTAIN = 2'd2,
    STG_RELEASE = 2'd3
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 3'd0,
    REG_KEY_LOW     = 3'd1,
    REG_KEY_HIGH    = 3'd2,
    REG_ATTACK      = 3'd3,
    REG_DECAY       = 3'd4,
    REG_SUSTAIN     = 3'd5,
    REG_RELEASE     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_ALLOC
  } fsm_state_t;

  // One voice entry as held in the voice RAM
  typedef struct packed {
    stage_t             stage;
    logic [NOTE_W-1:0]  note;
    logic [CH_W-1:0]    channel;
    logic [EM_W-1:0]    emitter;
    logic [LVL_W-1:0]   level;
  } voice_entry_t;

  // Envelope settings handed to the step unit
  typedef struct packed {
    logic [LVL_W-1:0] attack_step;
    logic [LVL_W-1:0] decay_step;
    logic [LVL_W-1:0] sustain_level;
    logic [LVL_W-1:0] release_step;
  } env_cfg_t;

endpackage

// ===== rtl/pva_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module pva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pva_env.sv =====
// ADSR envelope step for one voice, Q1.15 with clamping.
`timescale 1ns / 1ps

module pva_env import pva_pkg::*; (
  input  env_cfg_t     cfg,
  input  voice_entry_t cur,
  input  logic         released,
  output voice_entry_t nxt,
  output logic         freed
);

  stage_t                  st;
  logic [LVL_W-1:0]        sus;
  logic [LVL_W:0]          up;
  logic signed [LVL_W+1:0] dn_decay;
  logic signed [LVL_W+1:0] dn_rel;

  always_comb begin
    // sustain above one saturates
    sus      = (cfg.sustain_level > LEVEL_ONE[LVL_W-1:0]) ? LEVEL_ONE[LVL_W-1:0]
                                                          : cfg.sustain_level;
    st       = released ? STG_RELEASE : cur.stage;
    up       = {1'b0, cur.level} + {1'b0, cfg.attack_step};
    dn_decay = $signed({2'b00, cur.level}) - $signed({2'b00, cfg.decay_step});
    dn_rel   = $signed({2'b00, cur.level}) - $signed({2'b00, cfg.release_step});

    nxt       = cur;
    nxt.stage = st;
    freed     = 1'b0;
    case (st)
      STG_ATTACK: begin
        if (up >= LEVEL_ONE) begin
          nxt.level = LEVEL_ONE[LVL_W-1:0];
          nxt.stage = STG_DECAY;
        end else begin
          nxt.level = up[LVL_W-1:0];
        end
      end
      STG_DECAY: begin
        if (dn_decay <= $signed({2'b00, sus})) begin
          nxt.level = sus;
          nxt.stage = STG_SUSTAIN;
        end else begin
          nxt.level = dn_decay[LVL_W-1:0];
        end
      end
      STG_SUSTAIN: begin
        nxt.level = sus;
      end
      default: begin
        if (dn_rel <= 0) begin
          nxt.level = '0;
          freed     = 1'b1;
        end else begin
          nxt.level = dn_rel[LVL_W-1:0];
        end
      end
    endcase
  end

endmodule

// ===== rtl/poly_voice_allocator_adsr.sv =====
// Top level: polyphonic voice allocator with per-voice ADSR envelope.
`timescale 1ns / 1ps
//
//  Channel    Group                     Carries
//  ---------  ------------------------  ------------------------------------------
//  command    s_axis_tvalid/tready      tuser: command; tdata: channel, note
//  report     m_axis_tvalid/tready      tdata: one voice report; tlast: last voice
//  config     cfg_valid/cfg_ready       cfg_index: register, cfg_data: value
//
//  Every command walks the voice RAM one entry per cycle through its single read
//  port, pausing while a tick report stalls; a note-on then also visits each
//  emitter in turn to allocate. Tick reports leave through an output register.
//  Reset clears the active and released flags at once; RAM contents are not
//  cleared, since entries are only used while their voice is active.
//  Config transactions are taken only while idle, so registers never change
//  under a command.

module poly_voice_allocator_adsr import pva_pkg::*; #(
  parameter int NUM_VOICES   = 16,
  parameter int NUM_EMITTERS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // midi_channel[3:0], note_number[10:4], 0
  input  logic [1:0]            s_axis_tuser,   // command[1:0]
  // voice report stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // voice_index[5:0], voice_is_active[6], voice_note[13:7], voice_channel[17:14],
  // voice_emitter[19:18], envelope_stage[21:20], envelope_level[37:22],
  // is_released[38], 0
  output logic [39:0]           m_axis_tdata,
  output logic                  m_axis_tlast,   // last_report
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [VW-1:0]   LAST_IDX = VW'(NUM_VOICES - 1);
  localparam logic [EM_W-1:0] EM_LAST  = EM_W'(NUM_EMITTERS - 1);

  // configuration registers
  logic [EMITTER_SLOTS-1:0]       en_mask;
  logic [CFG_DATA_W-1:0]          key_lo;
  logic [CFG_DATA_W-1:0]          key_hi;
  logic [LVL_W-1:0]               atk_step;
  logic [LVL_W-1:0]               dcy_step;
  logic [LVL_W-1:0]               sus_level;
  logic [LVL_W-1:0]               rel_step;

  // command being worked on
  cmd_t                           cmd;
  logic [CH_W-1:0]                cmd_ch;
  logic [NOTE_W-1:0]              cmd_note;

  fsm_state_t                     state, state_next;
  logic [VW-1:0]                  idx;
  logic [EM_W-1:0]                em;
  logic [EMITTER_SLOTS-1:0]       found;      // emitter already retriggered a voice
  logic [EMITTER_SLOTS-1:0]       qual;       // emitter enabled and covers the note
  logic [VW-1:0]                  free_list [EMITTER_SLOTS];
  logic [2:0]                     free_cnt;
  logic [2:0]                     free_ptr;

  // voice flags, cleared at reset
  logic [NUM_VOICES-1:0]          active;
  logic [NUM_VOICES-1:0]          released;

  // RAM port signals
  logic                           ram_we, ram_re;
  logic [VW-1:0]                  ram_waddr, ram_raddr;
  voice_entry_t                   ram_wdata, cur;

  env_cfg_t                       env_cfg;
  voice_entry_t                   env_nxt;
  logic                           env_freed;

  logic                           in_take, can_emit, adv;
  logic                           cur_active, cur_rel;
  logic                           hit, off_hit, alloc_go, rep_active;
  logic [VW-1:0]                  alloc_slot;

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = (state == ST_IDLE);

  pva_ram #(
    .WIDTH ($bits(voice_entry_t)),
    .DEPTH (NUM_VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (cur)
  );

  assign env_cfg = '{attack_step:   atk_step,
                     decay_step:    dcy_step,
                     sustain_level: sus_level,
                     release_step:  rel_step};

  pva_env u_env (
    .cfg      (env_cfg),
    .cur      (cur),
    .released (cur_rel),
    .nxt      (env_nxt),
    .freed    (env_freed)
  );

  // key range and enable per emitter; inverted ranges cover nothing
  always_comb begin
    for (int e = 0; e < EMITTER_SLOTS; e++) begin
      qual[e] = (e < NUM_EMITTERS) && en_mask[e] &&
                (cmd_note >= key_lo[NOTE_W*e +: NOTE_W]) &&
                (cmd_note <= key_hi[NOTE_W*e +: NOTE_W]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && (s_axis_tuser inside {CMD_NOTE_ON, CMD_NOTE_OFF, CMD_TICK})) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (adv && idx == LAST_IDX) begin
          state_next = (cmd == CMD_NOTE_ON) ? ST_ALLOC : ST_IDLE;
        end
      end
      ST_ALLOC: begin
        if (em == EM_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    can_emit      = !m_axis_tvalid || m_axis_tready;
    // a tick only moves on when the report register can take the next voice
    adv           = (state == ST_SCAN) && ((cmd != CMD_TICK) || can_emit);
    ram_re        = (state == ST_FETCH) || (adv && idx != LAST_IDX);
    ram_raddr     = (state == ST_FETCH) ? '0 : idx + VW'(1);

    cur_active = active[idx];
    cur_rel    = released[idx];
    // a voice matches only its own emitter; first match per emitter wins
    hit     = (cmd == CMD_NOTE_ON) && cur_active && cur.note == cmd_note &&
              cur.channel == cmd_ch && qual[cur.emitter] && !found[cur.emitter];
    off_hit = (cmd == CMD_NOTE_OFF) && cur_active && cur.note == cmd_note &&
              cur.channel == cmd_ch;

    alloc_slot = free_list[free_ptr[1:0]];
    alloc_go   = (state == ST_ALLOC) && qual[em] && !found[em] && (free_ptr < free_cnt);

    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = env_nxt;
    if (adv && cmd == CMD_TICK && cur_active) begin
      ram_we = 1'b1;
    end else if (adv && hit) begin
      ram_we          = 1'b1;
      ram_wdata       = cur;
      ram_wdata.stage = STG_ATTACK;   // level is kept on retrigger
    end else if (alloc_go) begin
      ram_we    = 1'b1;
      ram_waddr = alloc_slot;
      ram_wdata = '{stage: STG_ATTACK, note: cmd_note, channel: cmd_ch,
                    emitter: em, level: '0};
    end

    rep_active = cur_active && !env_freed;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      en_mask       <= 4'h1;
      key_lo        <= '0;
      key_hi        <= 28'hFFFFFFF;
      atk_step      <= 16'd1024;
      dcy_step      <= 16'd512;
      sus_level     <= 16'd22938;
      rel_step      <= 16'd256;
      cmd           <= CMD_TICK;
      cmd_ch        <= '0;
      cmd_note      <= '0;
      idx           <= '0;
      em            <= '0;
      found         <= '0;
      free_cnt      <= '0;
      free_ptr      <= '0;
      active        <= '0;
      released      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE_MASK: en_mask   <= cfg_data[EMITTER_SLOTS-1:0];
          REG_KEY_LOW:     key_lo    <= cfg_data;
          REG_KEY_HIGH:    key_hi    <= cfg_data;
          REG_ATTACK:      atk_step  <= cfg_data[LVL_W-1:0];
          REG_DECAY:       dcy_step  <= cfg_data[LVL_W-1:0];
          REG_SUSTAIN:     sus_level <= cfg_data[LVL_W-1:0];
          REG_RELEASE:     rel_step  <= cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end

      if (in_take) begin
        cmd      <= cmd_t'(s_axis_tuser);
        cmd_ch   <= s_axis_tdata[CH_W-1:0];
        cmd_note <= s_axis_tdata[CH_W +: NOTE_W];
        idx      <= '0;
        em       <= '0;
        found    <= '0;
        free_cnt <= '0;
        free_ptr <= '0;
      end

      if (adv) begin
        if (idx != LAST_IDX) begin
          idx <= idx + VW'(1);
        end
        if (cmd == CMD_TICK && cur_active && env_freed) begin
          active[idx] <= 1'b0;
        end
        if (hit) begin
          released[idx]      <= 1'b0;
          found[cur.emitter] <= 1'b1;
        end
        if (off_hit) begin
          released[idx] <= 1'b1;
        end
        // lowest free voices in order, enough for every emitter
        if (cmd == CMD_NOTE_ON && !cur_active && free_cnt < 3'(EMITTER_SLOTS)) begin
          free_cnt <= free_cnt + 3'd1;
        end
      end

      if (state == ST_ALLOC) begin
        em <= em + EM_W'(1);
        if (alloc_go) begin
          active[alloc_slot]   <= 1'b1;
          released[alloc_slot] <= 1'b0;
          free_ptr             <= free_ptr + 3'd1;
        end
      end

      if (adv && cmd == CMD_TICK) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // free list and report payload
  always_ff @(posedge clk) begin
    if (adv && cmd == CMD_NOTE_ON && !cur_active && free_cnt < 3'(EMITTER_SLOTS)) begin
      free_list[free_cnt[1:0]] <= idx;
    end
    if (adv && cmd == CMD_TICK) begin
      m_axis_tlast <= (idx == LAST_IDX);
      if (rep_active) begin
        m_axis_tdata <= {1'b0, cur_rel, env_nxt.level, env_nxt.stage, env_nxt.emitter,
                         env_nxt.channel, env_nxt.note, 1'b1, IDX_W'(idx)};
      end else begin
        // inactive voices report zeros beside their index
        m_axis_tdata <= {33'd0, 1'b0, IDX_W'(idx)};
      end
    end
  end

endmodule
